@@ rtl/rsi_pkg.sv @@
// Shared types and constants for the ray and sphere intersection pipeline.
`timescale 1ns / 1ps
package rsi_pkg;

  localparam int CRD_W   = 32;
  localparam int H_W     = 67;
  localparam int A_W     = 64;
  localparam int C_W     = 68;
  localparam int M_W     = 66;
  localparam int P_W     = 132;
  localparam int D_W     = 133;
  localparam int R_W     = 66;
  localparam int N0_W    = 68;
  localparam int Q_W     = 32;
  localparam int CFG_A_W = 3;

  localparam logic [CFG_A_W-1:0] CFG_CENTER_X = 3'd0;
  localparam logic [CFG_A_W-1:0] CFG_CENTER_Y = 3'd1;
  localparam logic [CFG_A_W-1:0] CFG_CENTER_Z = 3'd2;
  localparam logic [CFG_A_W-1:0] CFG_RADIUS   = 3'd3;

  localparam logic signed [CRD_W-1:0] DIST_MAX = 32'sh7fff_ffff;
  localparam logic signed [CRD_W-1:0] DIST_MIN = 32'sh8000_0000;
  localparam logic [30:0] RADIUS_RST = 31'd65536;

  typedef struct packed {
    logic signed [CRD_W-1:0] px;
    logic signed [CRD_W-1:0] py;
    logic signed [CRD_W-1:0] pz;
    logic signed [CRD_W-1:0] dx;
    logic signed [CRD_W-1:0] dy;
    logic signed [CRD_W-1:0] dz;
  } ray_t;

  typedef struct packed {
    logic signed [H_W-1:0] h;
    logic [A_W-1:0]        a;
    logic                  c_neg;
  } aux_t;

  typedef struct packed {
    ray_t                  ray;
    logic signed [H_W-1:0] h;
    logic [A_W-1:0]        a;
    logic                  miss;
    logic                  zero;
    logic                  neg;
    logic                  big;
  } side_t;

  typedef struct packed {
    logic                    hit;
    logic signed [CRD_W-1:0] distance;
    logic signed [CRD_W-1:0] point_x;
    logic signed [CRD_W-1:0] point_y;
    logic signed [CRD_W-1:0] point_z;
  } res_t;

endpackage

@@ rtl/rsi_if.sv @@
// Channel interfaces for rays in, intersection results out and register writes.
`timescale 1ns / 1ps
interface rsi_in_if;
  logic               valid;
  logic               ready;
  logic signed [31:0] origin_x;
  logic signed [31:0] origin_y;
  logic signed [31:0] origin_z;
  logic signed [31:0] dir_x;
  logic signed [31:0] dir_y;
  logic signed [31:0] dir_z;
  modport source (output valid, origin_x, origin_y, origin_z, dir_x, dir_y, dir_z,
                  input ready);
  modport sink (input valid, origin_x, origin_y, origin_z, dir_x, dir_y, dir_z,
                output ready);
endinterface

interface rsi_out_if;
  logic               valid;
  logic               ready;
  logic               hit;
  logic signed [31:0] distance;
  logic signed [31:0] point_x;
  logic signed [31:0] point_y;
  logic signed [31:0] point_z;
  modport source (output valid, hit, distance, point_x, point_y, point_z, input ready);
  modport sink (input valid, hit, distance, point_x, point_y, point_z, output ready);
endinterface

interface rsi_cfg_if;
  logic        valid;
  logic        ready;
  logic [2:0]  addr;
  logic [31:0] data;
  modport source (output valid, addr, data, input ready);
  modport sink (input valid, addr, data, output ready);
endinterface

@@ rtl/rsi_wmul.sv @@
// Wide unsigned multiplier cut into limb products over three register stages.
`timescale 1ns / 1ps
module rsi_wmul #(
  parameter int W      = 66,
  parameter int SIDE_W = 8
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              en,
  input  logic              in_v,
  input  logic [W-1:0]      x,
  input  logic [W-1:0]      y,
  input  logic [SIDE_W-1:0] in_side,
  output logic              out_v,
  output logic [2*W-1:0]    prod,
  output logic [SIDE_W-1:0] out_side
);

  localparam int L  = (W + 2) / 3;
  localparam int XW = 3 * L;
  localparam int RW = 4 * L + 2;
  localparam int TW = 6 * L + 2;

  logic [XW-1:0]     xe, ye;
  logic [2*L-1:0]    pp_r [3][3];
  logic [RW-1:0]     row_r [3];
  logic [TW-1:0]     tot;
  logic [2*W-1:0]    prod_r;
  logic [2:0]        v_r;
  logic [SIDE_W-1:0] side_r [3];

  assign xe = XW'(x);
  assign ye = XW'(y);
  assign tot = TW'(row_r[0]) + (TW'(row_r[1]) << L) + (TW'(row_r[2]) << (2 * L));

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r <= '0;
    end else if (en) begin
      v_r <= {v_r[1:0], in_v};
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      for (int i = 0; i < 3; i++) begin
        for (int j = 0; j < 3; j++) begin
          pp_r[i][j] <= (2*L)'(xe[i*L +: L]) * (2*L)'(ye[j*L +: L]);
        end
        row_r[i] <= RW'(pp_r[i][0]) + (RW'(pp_r[i][1]) << L) + (RW'(pp_r[i][2]) << (2 * L));
      end
      prod_r    <= tot[2*W-1:0];
      side_r[0] <= in_side;
      side_r[1] <= side_r[0];
      side_r[2] <= side_r[1];
    end
  end

  assign out_v    = v_r[2];
  assign prod     = prod_r;
  assign out_side = side_r[2];

endmodule

@@ rtl/rsi_sqrt.sv @@
// Pipelined integer square root, one root bit per register stage.
`timescale 1ns / 1ps
module rsi_sqrt #(
  parameter int IN_W   = 132,
  parameter int SIDE_W = 8
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                en,
  input  logic                in_v,
  input  logic [IN_W-1:0]     radicand,
  input  logic [SIDE_W-1:0]   in_side,
  output logic                out_v,
  output logic [IN_W/2-1:0]   root,
  output logic [SIDE_W-1:0]   out_side
);

  localparam int N   = IN_W / 2;
  localparam int RMW = N + 2;

  logic [RMW-1:0]    rem_r [N];
  logic [N-1:0]      root_r [N];
  logic [IN_W-1:0]   x_r [N];
  logic [SIDE_W-1:0] side_r [N];
  logic [N-1:0]      v_r;

  logic [RMW-1:0]    rem_nxt [N];
  logic [N-1:0]      root_nxt [N];
  logic [IN_W-1:0]   x_nxt [N];

  logic [RMW-1:0]    rem_i, rem_sh, trial;
  logic [N-1:0]      root_i;
  logic [IN_W-1:0]   x_i;
  logic              take;

  always_comb begin
    for (int k = 0; k < N; k++) begin
      if (k == 0) begin
        rem_i  = '0;
        root_i = '0;
        x_i    = radicand;
      end else begin
        rem_i  = rem_r[k-1];
        root_i = root_r[k-1];
        x_i    = x_r[k-1];
      end
      rem_sh      = {rem_i[RMW-3:0], x_i[IN_W-1 -: 2]};
      trial       = {root_i, 2'b01};
      take        = (rem_sh >= trial);
      rem_nxt[k]  = take ? (rem_sh - trial) : rem_sh;
      root_nxt[k] = {root_i[N-2:0], take};
      x_nxt[k]    = x_i << 2;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r <= '0;
    end else if (en) begin
      v_r <= {v_r[N-2:0], in_v};
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      for (int k = 0; k < N; k++) begin
        rem_r[k]  <= rem_nxt[k];
        root_r[k] <= root_nxt[k];
        x_r[k]    <= x_nxt[k];
        side_r[k] <= (k == 0) ? in_side : side_r[(k == 0) ? 0 : k-1];
      end
    end
  end

  assign out_v    = v_r[N-1];
  assign root     = root_r[N-1];
  assign out_side = side_r[N-1];

endmodule

@@ rtl/ray_sphere_intersection.sv @@
// Ray against sphere intersection pipeline, top level.
`timescale 1ns / 1ps
// Each input beat carries one ray (origin and direction, signed fixed point with
// FRAC_BITS fraction bits) and yields exactly one result beat: hit flag, nearer
// root distance and hit point, all saturated to 32 bits, zero on a miss.
// The sphere center and radius are written through the configuration channel,
// which is always ready; write it only while no ray is in flight.
// The pipeline depth is set by the 66-stage square root, the 32-stage divider
// and the wide limb multipliers. Throughput is one ray per cycle unless the
// output buffer is full. A two-entry output buffer sits after the pipeline:
// the input stays ready while a result waits, and the whole pipeline holds
// only once the buffer is full, so nothing is dropped or repeated.
// Reset clears all valid bits and the output buffer and loads the center with
// zero and the radius with one unit.
module ray_sphere_intersection
  import rsi_pkg::*;
#(
  parameter int FRAC_BITS = 16
) (
  input  logic      clk,
  input  logic      rst_n,
  rsi_in_if.sink    in_ch,
  rsi_out_if.source out_ch,
  rsi_cfg_if.sink   cfg_ch
);

  localparam int NUM_W = N0_W + FRAC_BITS;
  localparam int WD    = (NUM_W > A_W + Q_W) ? NUM_W : A_W + Q_W;
  localparam logic [Q_W:0] CE_LIM = (Q_W+1)'(1) << (Q_W - 1);
  localparam int SIDE_W = $bits(side_t);

  function automatic logic signed [CRD_W-1:0] sat32(input logic signed [64:0] v);
    if (v > 65'(DIST_MAX)) begin
      return DIST_MAX;
    end else if (v < 65'(DIST_MIN)) begin
      return DIST_MIN;
    end
    return v[CRD_W-1:0];
  endfunction

  logic signed [CRD_W-1:0] cx_r, cy_r, cz_r;
  logic [30:0]             rad_r;

  logic en;
  logic ov_r, sk_v_r;
  res_t od_r, sk_d_r, res_nxt;
  logic push;

  assign en          = !sk_v_r;
  assign in_ch.ready = en;
  assign cfg_ch.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cx_r  <= '0;
      cy_r  <= '0;
      cz_r  <= '0;
      rad_r <= RADIUS_RST;
    end else if (cfg_ch.valid) begin
      unique case (cfg_ch.addr)
        CFG_CENTER_X: cx_r  <= cfg_ch.data;
        CFG_CENTER_Y: cy_r  <= cfg_ch.data;
        CFG_CENTER_Z: cz_r  <= cfg_ch.data;
        CFG_RADIUS:   rad_r <= cfg_ch.data[30:0];
        default: ;
      endcase
    end
  end

  // Offsets from the center, then the per-axis products, then the sums, then the magnitudes of h and c.
  logic                    v1_r, v2_r, v3_r, v4_r;
  ray_t                    ray1_r, ray2_r, ray3_r;
  logic signed [32:0]      avx1_r, avy1_r, avz1_r;
  logic signed [63:0]      ddx2_r, ddy2_r, ddz2_r;
  logic signed [64:0]      dvx2_r, dvy2_r, dvz2_r;
  logic signed [65:0]      aax2_r, aay2_r, aaz2_r;
  logic [61:0]             rr2_r;
  logic [A_W-1:0]          a3_r;
  logic signed [H_W-1:0]   h3_r;
  logic signed [C_W-1:0]   c3_r;
  logic [M_W-1:0]          hm4_r, cm4_r;
  ray_t                    ray4_r;
  aux_t                    aux4_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
      v2_r <= 1'b0;
      v3_r <= 1'b0;
      v4_r <= 1'b0;
    end else if (en) begin
      v1_r <= in_ch.valid;
      v2_r <= v1_r;
      v3_r <= v2_r;
      v4_r <= v3_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      ray1_r <= '{px: in_ch.origin_x, py: in_ch.origin_y, pz: in_ch.origin_z,
                  dx: in_ch.dir_x, dy: in_ch.dir_y, dz: in_ch.dir_z};
      avx1_r <= 33'(in_ch.origin_x) - 33'(cx_r);
      avy1_r <= 33'(in_ch.origin_y) - 33'(cy_r);
      avz1_r <= 33'(in_ch.origin_z) - 33'(cz_r);

      ray2_r <= ray1_r;
      ddx2_r <= 64'(ray1_r.dx) * 64'(ray1_r.dx);
      ddy2_r <= 64'(ray1_r.dy) * 64'(ray1_r.dy);
      ddz2_r <= 64'(ray1_r.dz) * 64'(ray1_r.dz);
      dvx2_r <= 65'(ray1_r.dx) * 65'(avx1_r);
      dvy2_r <= 65'(ray1_r.dy) * 65'(avy1_r);
      dvz2_r <= 65'(ray1_r.dz) * 65'(avz1_r);
      aax2_r <= 66'(avx1_r) * 66'(avx1_r);
      aay2_r <= 66'(avy1_r) * 66'(avy1_r);
      aaz2_r <= 66'(avz1_r) * 66'(avz1_r);
      rr2_r  <= 62'(rad_r) * 62'(rad_r);

      ray3_r <= ray2_r;
      a3_r   <= $unsigned(ddx2_r) + $unsigned(ddy2_r) + $unsigned(ddz2_r);
      h3_r   <= H_W'(dvx2_r) + H_W'(dvy2_r) + H_W'(dvz2_r);
      c3_r   <= C_W'(aax2_r) + C_W'(aay2_r) + C_W'(aaz2_r) - C_W'(rr2_r);

      ray4_r       <= ray3_r;
      hm4_r        <= h3_r[H_W-1] ? M_W'(-h3_r) : M_W'(h3_r);
      cm4_r        <= c3_r[C_W-1] ? M_W'(-c3_r) : M_W'(c3_r);
      aux4_r.h     <= h3_r;
      aux4_r.a     <= a3_r;
      aux4_r.c_neg <= c3_r[C_W-1];
    end
  end

  // h squared and a times c on the wide multipliers.
  logic                        hh_v, ac_v;
  logic [P_W-1:0]              hh, ac;
  logic [$bits(ray_t)-1:0]     hh_side;
  logic [$bits(aux_t)-1:0]     ac_side;
  aux_t                        aux7;

  rsi_wmul #(.W(M_W), .SIDE_W($bits(ray_t))) u_mul_hh (
    .clk(clk), .rst_n(rst_n), .en(en), .in_v(v4_r),
    .x(hm4_r), .y(hm4_r), .in_side(ray4_r),
    .out_v(hh_v), .prod(hh), .out_side(hh_side)
  );

  rsi_wmul #(.W(M_W), .SIDE_W($bits(aux_t))) u_mul_ac (
    .clk(clk), .rst_n(rst_n), .en(en), .in_v(v4_r),
    .x(M_W'(aux4_r.a)), .y(cm4_r), .in_side(aux4_r),
    .out_v(ac_v), .prod(ac), .out_side(ac_side)
  );

  assign aux7 = aux_t'(ac_side);

  logic [D_W-1:0] disc;
  logic           v8_r;
  logic [P_W-1:0] sq8_r;
  side_t          side8_r;

  assign disc = aux7.c_neg ? (D_W'(hh) + D_W'(ac)) : (D_W'(hh) - D_W'(ac));

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v8_r <= 1'b0;
    end else if (en) begin
      v8_r <= hh_v;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      sq8_r         <= disc[D_W-1] ? '0 : disc[P_W-1:0];
      side8_r.ray   <= ray_t'(hh_side);
      side8_r.h     <= aux7.h;
      side8_r.a     <= aux7.a;
      side8_r.miss  <= disc[D_W-1];
      side8_r.zero  <= (aux7.a == '0);
      side8_r.neg   <= 1'b0;
      side8_r.big   <= 1'b0;
    end
  end

  logic              sq_v;
  logic [R_W-1:0]    sq_root;
  logic [SIDE_W-1:0] sq_side_bits;
  side_t             sq_side;

  rsi_sqrt #(.IN_W(P_W), .SIDE_W(SIDE_W)) u_sqrt (
    .clk(clk), .rst_n(rst_n), .en(en), .in_v(v8_r),
    .radicand(sq8_r), .in_side(side8_r),
    .out_v(sq_v), .root(sq_root), .out_side(sq_side_bits)
  );

  assign sq_side = side_t'(sq_side_bits);

  // Numerator magnitude, overflow check, then restoring division.
  logic signed [N0_W-1:0]  num;
  logic signed [NUM_W-1:0] numf;
  logic                    va_r, vb_r;
  logic [NUM_W-1:0]        mag_a_r;
  side_t                   sa_r, sb_r;
  side_t                   sa_nxt, sb_nxt;
  logic [WD-1:0]           remb_r;

  assign num  = -N0_W'(sq_side.h) - $signed(N0_W'(sq_root));
  assign numf = NUM_W'(num) <<< FRAC_BITS;

  always_comb begin
    sa_nxt     = sq_side;
    sa_nxt.neg = num[N0_W-1];
    sb_nxt     = sa_r;
    sb_nxt.big = (WD'(mag_a_r) >= (WD'(sa_r.a) << Q_W));
  end

  logic [WD-1:0]  drem_r [Q_W];
  logic [Q_W-1:0] dq_r [Q_W];
  side_t          ds_r [Q_W];
  logic [Q_W-1:0] dv_r;

  logic [WD-1:0]  drem_nxt [Q_W];
  logic [Q_W-1:0] dq_nxt [Q_W];
  logic [WD-1:0]  rem_in, dsh;
  logic [Q_W-1:0] q_in;
  side_t          s_in;
  logic           ge;

  always_comb begin
    for (int j = 0; j < Q_W; j++) begin
      if (j == 0) begin
        rem_in = remb_r;
        q_in   = '0;
        s_in   = sb_r;
      end else begin
        rem_in = drem_r[j-1];
        q_in   = dq_r[j-1];
        s_in   = ds_r[j-1];
      end
      dsh         = WD'(s_in.a) << (Q_W - 1 - j);
      ge          = (rem_in >= dsh);
      drem_nxt[j] = ge ? (rem_in - dsh) : rem_in;
      dq_nxt[j]   = {q_in[Q_W-2:0], ge};
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      va_r <= 1'b0;
      vb_r <= 1'b0;
      dv_r <= '0;
    end else if (en) begin
      va_r <= sq_v;
      vb_r <= va_r;
      dv_r <= {dv_r[Q_W-2:0], vb_r};
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      mag_a_r <= num[N0_W-1] ? NUM_W'(-numf) : NUM_W'(numf);
      sa_r    <= sa_nxt;

      remb_r  <= WD'(mag_a_r);
      sb_r    <= sb_nxt;

      for (int j = 0; j < Q_W; j++) begin
        drem_r[j] <= drem_nxt[j];
        dq_r[j]   <= dq_nxt[j];
        ds_r[j]   <= (j == 0) ? sb_r : ds_r[(j == 0) ? 0 : j-1];
      end
    end
  end

  // Distance with saturation, then the point products.
  logic [Q_W-1:0]          qf;
  logic [Q_W:0]            ce;
  side_t                   sf;
  logic signed [CRD_W-1:0] dist_nxt;
  logic                    vc_r, vd_r;
  logic signed [CRD_W-1:0] dist_c_r;
  ray_t                    ray_c_r, ray_d_r;
  logic                    miss_c_r, miss_d_r;
  logic signed [63:0]      prx_r, pry_r, prz_r;

  assign qf = dq_r[Q_W-1];
  assign sf = ds_r[Q_W-1];
  assign ce = {1'b0, qf} + (Q_W+1)'(|drem_r[Q_W-1]);

  always_comb begin
    if (sf.miss || sf.zero) begin
      dist_nxt = '0;
    end else if (!sf.neg) begin
      dist_nxt = (sf.big || qf[Q_W-1]) ? DIST_MAX : $signed(qf);
    end else begin
      dist_nxt = (sf.big || (ce > CE_LIM)) ? DIST_MIN : CRD_W'(-ce);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vc_r <= 1'b0;
      vd_r <= 1'b0;
    end else if (en) begin
      vc_r <= dv_r[Q_W-1];
      vd_r <= vc_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      dist_c_r <= dist_nxt;
      ray_c_r  <= sf.ray;
      miss_c_r <= sf.miss;

      prx_r    <= 64'(ray_c_r.dx) * 64'(dist_c_r);
      pry_r    <= 64'(ray_c_r.dy) * 64'(dist_c_r);
      prz_r    <= 64'(ray_c_r.dz) * 64'(dist_c_r);
      ray_d_r  <= ray_c_r;
      miss_d_r <= miss_c_r;
    end
  end

  always_comb begin
    res_nxt.hit = !miss_d_r;
    if (miss_d_r) begin
      res_nxt.distance = '0;
      res_nxt.point_x  = '0;
      res_nxt.point_y  = '0;
      res_nxt.point_z  = '0;
    end else begin
      res_nxt.distance = dist_c_r;
      res_nxt.point_x  = sat32(65'(ray_d_r.px) + 65'(prx_r >>> FRAC_BITS));
      res_nxt.point_y  = sat32(65'(ray_d_r.py) + 65'(pry_r >>> FRAC_BITS));
      res_nxt.point_z  = sat32(65'(ray_d_r.pz) + 65'(prz_r >>> FRAC_BITS));
    end
  end

  // The distance stage has moved on by the time the products are used, so keep it.
  logic signed [CRD_W-1:0] dist_d_r;
  always_ff @(posedge clk) begin
    if (en) begin
      dist_d_r <= dist_c_r;
    end
  end

  // Two-entry output buffer.
  assign push = en && vd_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ov_r   <= 1'b0;
      sk_v_r <= 1'b0;
    end else if (!ov_r || out_ch.ready) begin
      ov_r   <= sk_v_r || push;
      sk_v_r <= 1'b0;
    end else if (push) begin
      sk_v_r <= 1'b1;
    end
  end

  res_t res_fix;
  always_comb begin
    res_fix = res_nxt;
    if (!miss_d_r) begin
      res_fix.distance = dist_d_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!ov_r || out_ch.ready) begin
      od_r <= sk_v_r ? sk_d_r : res_fix;
    end else if (push) begin
      sk_d_r <= res_fix;
    end
  end

  assign out_ch.valid    = ov_r;
  assign out_ch.hit      = od_r.hit;
  assign out_ch.distance = od_r.distance;
  assign out_ch.point_x  = od_r.point_x;
  assign out_ch.point_y  = od_r.point_y;
  assign out_ch.point_z  = od_r.point_z;

  a_mul_align: assert property (@(posedge clk) disable iff (!rst_n) hh_v == ac_v)
    else $error("wide multiplier valid bits out of step");

  a_skid_order: assert property (@(posedge clk) disable iff (!rst_n) sk_v_r |-> ov_r)
    else $error("skid entry held while output register empty");

  a_miss_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_ch.valid && !out_ch.hit) |-> (out_ch.distance == 0 && out_ch.point_x == 0 &&
                                       out_ch.point_y == 0 && out_ch.point_z == 0))
    else $error("miss result with nonzero fields");

endmodule

@@ tb/rsi_checker.sv @@
// Watches the ray, result and register channels, predicts each result and compares it.
`timescale 1ns / 1ps
module rsi_checker
  import rsi_pkg::*;
#(
  parameter int FRAC_BITS = 16
) (
  input  logic clk,
  input  logic rst_n,
  rsi_in_if    in_ch,
  rsi_out_if   out_ch,
  rsi_cfg_if   cfg_ch,
  output int   fails,
  output int   pending,
  output int   hits_seen,
  output int   results_seen
);

  typedef logic signed [159:0] wide_t;

  logic signed [CRD_W-1:0] sph_center [3];
  logic [30:0]             sph_radius;
  res_t                    expected_hits[$];

  function automatic wide_t clamp32(wide_t v);
    if (v > wide_t'(DIST_MAX)) return wide_t'(DIST_MAX);
    if (v < wide_t'(DIST_MIN)) return wide_t'(DIST_MIN);
    return v;
  endfunction

  function automatic res_t predict_intersection(ray_t r);
    wide_t p [3];
    wide_t d [3];
    wide_t av, a, h, c, disc, root, trial, num, q, rem, dist_val, prod;
    res_t  res;
    p[0] = r.px; p[1] = r.py; p[2] = r.pz;
    d[0] = r.dx; d[1] = r.dy; d[2] = r.dz;
    a = 0;
    h = 0;
    c = -(wide_t'({1'b0, sph_radius}) * wide_t'({1'b0, sph_radius}));
    for (int i = 0; i < 3; i++) begin
      av = p[i] - wide_t'(sph_center[i]);
      a += d[i] * d[i];
      h += d[i] * av;
      c += av * av;
    end
    disc = h * h - a * c;
    res = '0;
    if (disc < 0) return res;
    res.hit = 1'b1;
    if (a == 0) begin
      res.point_x = r.px;
      res.point_y = r.py;
      res.point_z = r.pz;
      return res;
    end
    root = 0;
    for (int k = 67; k >= 0; k--) begin
      trial = root | (wide_t'(1) << k);
      if (trial * trial <= disc) root = trial;
    end
    num = (-h - root) <<< FRAC_BITS;
    q = num / a;
    rem = num % a;
    if (rem != 0 && num < 0) q = q - 1;
    dist_val = clamp32(q);
    res.distance = dist_val[31:0];
    prod = clamp32(p[0] + ((d[0] * dist_val) >>> FRAC_BITS));
    res.point_x = prod[31:0];
    prod = clamp32(p[1] + ((d[1] * dist_val) >>> FRAC_BITS));
    res.point_y = prod[31:0];
    prod = clamp32(p[2] + ((d[2] * dist_val) >>> FRAC_BITS));
    res.point_z = prod[31:0];
    return res;
  endfunction

  always @(posedge clk) begin
    res_t exp_res;
    ray_t ray;
    if (!rst_n) begin
      sph_center[0] <= '0;
      sph_center[1] <= '0;
      sph_center[2] <= '0;
      sph_radius <= RADIUS_RST;
      expected_hits.delete();
      fails <= 0;
      hits_seen <= 0;
      results_seen <= 0;
    end else begin
      if (cfg_ch.valid && cfg_ch.ready) begin
        case (cfg_ch.addr)
          CFG_CENTER_X: sph_center[0] <= cfg_ch.data;
          CFG_CENTER_Y: sph_center[1] <= cfg_ch.data;
          CFG_CENTER_Z: sph_center[2] <= cfg_ch.data;
          CFG_RADIUS:   sph_radius <= cfg_ch.data[30:0];
          default: ;
        endcase
      end
      if (in_ch.valid && in_ch.ready) begin
        ray = '{in_ch.origin_x, in_ch.origin_y, in_ch.origin_z,
                in_ch.dir_x, in_ch.dir_y, in_ch.dir_z};
        expected_hits.push_back(predict_intersection(ray));
      end
      if (out_ch.valid && out_ch.ready) begin
        results_seen <= results_seen + 1;
        if (out_ch.hit) hits_seen <= hits_seen + 1;
        if (expected_hits.size() == 0) begin
          $error("result beat with no ray waiting");
          fails <= fails + 1;
        end else begin
          exp_res = expected_hits.pop_front();
          if (out_ch.hit !== exp_res.hit) begin
            $error("hit: expected %0d, got %0d", exp_res.hit, out_ch.hit);
            fails <= fails + 1;
          end else if (out_ch.distance !== exp_res.distance) begin
            $error("distance: expected %0d, got %0d", exp_res.distance, out_ch.distance);
            fails <= fails + 1;
          end else if (out_ch.point_x !== exp_res.point_x) begin
            $error("point_x: expected %0d, got %0d", exp_res.point_x, out_ch.point_x);
            fails <= fails + 1;
          end else if (out_ch.point_y !== exp_res.point_y) begin
            $error("point_y: expected %0d, got %0d", exp_res.point_y, out_ch.point_y);
            fails <= fails + 1;
          end else if (out_ch.point_z !== exp_res.point_z) begin
            $error("point_z: expected %0d, got %0d", exp_res.point_z, out_ch.point_z);
            fails <= fails + 1;
          end
        end
      end
    end
    pending = expected_hits.size();
  end

endmodule

@@ tb/ray_sphere_intersection_tb.sv @@
// Top of the testbench: clock, reset, ray and register stimulus, result stalls and verdict.
`timescale 1ns / 1ps
module ray_sphere_intersection_tb;
  import rsi_pkg::*;

  localparam logic [CFG_A_W-1:0] CFG_UNUSED = 3'd5;
  localparam int DRAIN_CYCLES = 130;
  localparam int HOLD_CYCLES = 400;
  localparam int WATCHDOG_LIMIT = 6000;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  int   fails, pending, hits_seen, results_seen;
  int   rays_sent;
  int   idle_cycles;
  bit   hold_out;
  bit   no_gaps;
  logic signed [31:0] cur_center [3];

  rsi_in_if  in_ch();
  rsi_out_if out_ch();
  rsi_cfg_if cfg_ch();

  ray_sphere_intersection dut (
    .clk(clk), .rst_n(rst_n), .in_ch(in_ch), .out_ch(out_ch), .cfg_ch(cfg_ch)
  );

  rsi_checker chk (
    .clk(clk), .rst_n(rst_n), .in_ch(in_ch), .out_ch(out_ch), .cfg_ch(cfg_ch),
    .fails(fails), .pending(pending), .hits_seen(hits_seen), .results_seen(results_seen)
  );

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  function automatic logic signed [31:0] clip32(longint v);
    if (v > 64'sd2147483647) return 32'sh7fff_ffff;
    if (v < -64'sd2147483648) return 32'sh8000_0000;
    return v[31:0];
  endfunction

  function automatic longint rand_scaled(int k);
    logic signed [31:0] raw;
    raw = $urandom;
    return longint'(raw) >>> (31 - k);
  endfunction

  task automatic write_reg(logic [CFG_A_W-1:0] idx, logic [31:0] value);
    cfg_ch.addr <= idx;
    cfg_ch.data <= value;
    cfg_ch.valid <= 1'b1;
    @(posedge clk);
    while (!cfg_ch.ready) @(posedge clk);
    cfg_ch.valid <= 1'b0;
    case (idx)
      CFG_CENTER_X: cur_center[0] = value;
      CFG_CENTER_Y: cur_center[1] = value;
      CFG_CENTER_Z: cur_center[2] = value;
      default: ;
    endcase
    @(posedge clk);
  endtask

  task automatic set_sphere(logic [31:0] cx, logic [31:0] cy, logic [31:0] cz,
                            logic [31:0] rad);
    write_reg(CFG_CENTER_X, cx);
    write_reg(CFG_CENTER_Y, cy);
    write_reg(CFG_CENTER_Z, cz);
    write_reg(CFG_RADIUS, rad);
  endtask

  task automatic drain();
    in_ch.valid <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task automatic send_ray(ray_t r);
    int gap;
    gap = no_gaps ? 0 : $urandom_range(0, 10);
    if (gap > 0) begin
      in_ch.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_ch.origin_x <= r.px;
    in_ch.origin_y <= r.py;
    in_ch.origin_z <= r.pz;
    in_ch.dir_x <= r.dx;
    in_ch.dir_y <= r.dy;
    in_ch.dir_z <= r.dz;
    in_ch.valid <= 1'b1;
    @(posedge clk);
    while (!in_ch.ready) @(posedge clk);
    rays_sent++;
  endtask

  function automatic ray_t aimed_ray();
    ray_t r;
    longint off;
    int scale;
    int k;
    k = $urandom_range(8, 28);
    for (int i = 0; i < 3; i++) begin
      off = rand_scaled(k);
      scale = $urandom_range(0, 3);
      case (i)
        0: begin
          r.px = clip32(longint'(cur_center[0]) + off);
          r.dx = clip32((-off >>> scale) + rand_scaled(k - 4));
        end
        1: begin
          r.py = clip32(longint'(cur_center[1]) + off);
          r.dy = clip32((-off >>> scale) + rand_scaled(k - 4));
        end
        default: begin
          r.pz = clip32(longint'(cur_center[2]) + off);
          r.dz = clip32((-off >>> scale) + rand_scaled(k - 4));
        end
      endcase
    end
    return r;
  endfunction

  function automatic ray_t random_ray();
    ray_t r;
    case ($urandom_range(0, 9))
      0, 1: r = {$urandom, $urandom, $urandom, $urandom, $urandom, $urandom};
      2: begin
        r = aimed_ray();
        r.dx = 0; r.dy = 0; r.dz = 0;
      end
      default: r = aimed_ray();
    endcase
    return r;
  endfunction

  task automatic random_phase(int count);
    for (int n = 0; n < count; n++) begin
      if (n % 60 == 0) no_gaps = ($urandom_range(0, 3) == 0);
      send_ray(random_ray());
    end
    no_gaps = 1'b0;
  endtask

  always @(posedge clk) begin
    if (!rst_n || (in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready) ||
        (cfg_ch.valid && cfg_ch.ready)) begin
      idle_cycles <= 0;
    end else begin
      idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= WATCHDOG_LIMIT) begin
        $display("simulation failed");
        $finish;
      end
    end
  end

  initial begin
    int w;
    out_ch.ready = 1'b0;
    @(posedge clk);
    while (!rst_n) @(posedge clk);
    forever begin
      if (hold_out) begin
        out_ch.ready <= 1'b0;
        repeat (HOLD_CYCLES) @(posedge clk);
        hold_out = 1'b0;
      end else begin
        w = $urandom_range(0, 10);
        if (no_gaps) w = 0;
        if (w > 0) begin
          out_ch.ready <= 1'b0;
          repeat (w) @(posedge clk);
        end
        out_ch.ready <= 1'b1;
        @(posedge clk);
        while (!(out_ch.valid && out_ch.ready) && !hold_out) @(posedge clk);
      end
    end
  end

  initial begin
    ray_t r;
    logic signed [31:0] one;
    one = 32'sd65536;
    in_ch.valid = 1'b0;
    in_ch.origin_x = '0; in_ch.origin_y = '0; in_ch.origin_z = '0;
    in_ch.dir_x = '0; in_ch.dir_y = '0; in_ch.dir_z = '0;
    cfg_ch.valid = 1'b0;
    cfg_ch.addr = '0;
    cfg_ch.data = '0;
    cur_center[0] = '0; cur_center[1] = '0; cur_center[2] = '0;
    rays_sent = 0;
    hold_out = 1'b0;
    no_gaps = 1'b0;
    repeat (6) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Default unit sphere at the origin: hits from outside, inside and behind,
    // a tangent ray, a clean miss, a zero direction and the field extremes.
    send_ray('{0, 0, -5 * one, 0, 0, one});
    send_ray('{0, 0, 0, 0, 0, one});
    send_ray('{0, 0, 5 * one, 0, 0, one});
    send_ray('{0, one, -5 * one, 0, 0, one});
    send_ray('{0, 2 * one, -5 * one, 0, 0, one});
    send_ray('{3 * one, 4 * one, 0, 0, 0, 0});
    send_ray('{32'sh7fff_ffff, 32'sh7fff_ffff, 32'sh7fff_ffff,
               32'sh8000_0000, 32'sh8000_0000, 32'sh8000_0000});
    send_ray('{32'sh8000_0000, 32'sh8000_0000, 32'sh8000_0000,
               32'sh7fff_ffff, 32'sh7fff_ffff, 32'sh7fff_ffff});
    send_ray('{32'sh8000_0000, 0, 0, 32'sh7fff_ffff, 0, 0});
    send_ray('{-5 * one, 0, 0, 1, 0, 0});
    send_ray('{0, 0, -5 * one, 0, 0, 32'sh7fff_ffff});
    send_ray('{0, 0, 0, -1, -1, -1});
    send_ray('{-1, -1, -1, 0, 0, 0});
    drain();

    // Register extremes: zero radius, largest radius, centers at both ends.
    write_reg(CFG_UNUSED, 32'hffff_ffff);
    set_sphere(32'h7fff_ffff, 32'h8000_0000, 32'h7fff_ffff, 32'h0);
    send_ray('{32'sh7fff_0000, 32'sh8001_0000, 32'sh7fff_0000, 0, one, 0});
    send_ray('{0, 0, 0, 32'sh7fff_ffff, 32'sh8000_0000, 32'sh7fff_ffff});
    r = aimed_ray();
    send_ray(r);
    drain();
    set_sphere(32'h8000_0000, 32'h7fff_ffff, 32'h8000_0000, 32'h7fff_ffff);
    send_ray('{0, 0, 0, 0, 0, 0});
    send_ray('{32'sh7fff_ffff, 32'sh8000_0000, 32'sh7fff_ffff, one, -one, one});
    send_ray('{32'sh7fff_ffff, 32'sh8000_0000, 32'sh7fff_ffff, 0, 0, 0});
    random_phase(200);
    drain();

    set_sphere(0, 0, 0, 32'(RADIUS_RST));
    random_phase(260);
    drain();

    // Long output stall with a steady ray stream to back the pipeline up.
    set_sphere($urandom_range(0, 1 << 24), -$urandom_range(0, 1 << 24), 32'h0100_0000,
               $urandom_range(1 << 14, 1 << 22));
    no_gaps = 1'b1;
    hold_out = 1'b1;
    for (int n = 0; n < 300; n++) send_ray(random_ray());
    no_gaps = 1'b0;
    drain();

    for (int ph = 0; ph < 3; ph++) begin
      set_sphere(32'(rand_scaled(26)), 32'(rand_scaled(26)), 32'(rand_scaled(26)),
                 $urandom_range(0, 1 << (18 + 3 * ph)));
      random_phase(250);
      drain();
    end

    $display("rays sent %0d, results checked %0d, hits %0d, over several sphere setups",
             rays_sent, results_seen, hits_seen);
    $display("including register extremes, zero direction, tangent and a long output stall");
    if (fails == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

endmodule

@@ sim.f @@
rtl/rsi_pkg.sv
rtl/rsi_if.sv
rtl/rsi_wmul.sv
rtl/rsi_sqrt.sv
rtl/ray_sphere_intersection.sv
tb/rsi_checker.sv
tb/ray_sphere_intersection_tb.sv
